>>> hw/rtl/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache tag block.
package salc_pkg;

    localparam int MAX_SET_BITS = 8;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_W       = 32;

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = MAX_SET_BITS;
    localparam int WAY_W    = $clog2(MAX_WAYS);
    localparam int RANK_W   = WAY_W;
    localparam int TAG_W    = ADDR_W;

    localparam int SETB_W     = 4;
    localparam int BLKB_W     = 5;
    localparam int WAYS_W     = 4;
    localparam int SHIFT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

    // access kinds
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;
    localparam logic [1:0] ACT_IGNORE = 2'd3;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_MISS  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        t_outcome    outcome;
        logic        last_of_item;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } t_rsp;

    // one memory row holds a whole set
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } t_set_row;

endpackage

>>> hw/rtl/salc_access.sv
// Lookup, fill/victim choice and LRU rank update for one set row.
module salc_access import salc_pkg::*; (
    input  t_set_row           i_row,
    input  logic [TAG_W-1:0]   i_tag,
    input  logic [WAYS_W-1:0]  i_ways,
    output t_set_row           o_row,
    output t_outcome           o_outcome
);

    logic [MAX_WAYS-1:0] act;
    logic [MAX_WAYS-1:0] hit;
    logic [MAX_WAYS-1:0] inv;
    logic [WAY_W-1:0]    hit_w;
    logic [WAY_W-1:0]    inv_w;
    logic [WAY_W-1:0]    vic_w;
    logic [WAY_W-1:0]    sel_w;
    logic [RANK_W-1:0]   old_rank;
    logic                old_max;

    always_comb begin
        for (int j = 0; j < MAX_WAYS; j++) begin
            act[j] = WAYS_W'(j) < i_ways;
            hit[j] = act[j] && i_row.valid[j] && (i_row.tag[j] == i_tag);
            inv[j] = act[j] && !i_row.valid[j];
        end

        // lowest index wins
        hit_w = '0;
        inv_w = '0;
        for (int j = MAX_WAYS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hit_w = WAY_W'(j);
            end
            if (inv[j]) begin
                inv_w = WAY_W'(j);
            end
        end

        // highest rank, ties to the lowest way
        vic_w = '0;
        for (int j = 1; j < MAX_WAYS; j++) begin
            if (act[j] && (i_row.rank[j] > i_row.rank[vic_w])) begin
                vic_w = WAY_W'(j);
            end
        end

        priority if (|hit) begin
            sel_w     = hit_w;
            o_outcome = OUT_HIT;
        end else if (|inv) begin
            sel_w     = inv_w;
            o_outcome = OUT_MISS;
        end else begin
            sel_w     = vic_w;
            o_outcome = OUT_EVICT;
        end

        // a filled line counts as older than every other line
        old_max  = !(|hit);
        old_rank = i_row.rank[hit_w];

        o_row = i_row;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if (act[j] && (WAY_W'(j) != sel_w) && i_row.valid[j] &&
                (old_max || (i_row.rank[j] < old_rank)) &&
                (i_row.rank[j] < RANK_W'(MAX_WAYS - 1))) begin
                o_row.rank[j] = i_row.rank[j] + 1'b1;
            end
        end
        o_row.rank[sel_w]  = '0;
        o_row.valid[sel_w] = 1'b1;
        o_row.tag[sel_w]   = i_tag;
    end

endmodule

>>> hw/rtl/set_assoc_lru_cache_tags.sv
// Top level: set-associative cache tag array with LRU replacement and hit/miss totals.
// One request is taken at a time. A load or store first has the registered read of the
// set's row from the tag memory, then the lookup, the rank update, the write-back of the
// row and the registering of the result. A modify adds a second access, which works on
// the row kept from the first. Action 3 is taken without starting an access and gives
// no result. A stalled result output holds the block in the update step. Valid state is
// one flip-flop per set, cleared by reset, so no clearing pass is needed and the block
// takes requests right after reset.
module set_assoc_lru_cache_tags import salc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_req                  i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_rsp                  o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_MOD2 = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [SETB_W-1:0]   r_set_bits;
    logic [BLKB_W-1:0]   r_blk_bits;
    logic [WAYS_W-1:0]   r_ways;

    t_set_row            r_mem [NUM_SETS];
    logic [NUM_SETS-1:0] r_set_live;
    t_set_row            r_rd_row;
    logic                r_rd_live;
    t_set_row            r_row_hold;

    logic [SET_W-1:0]    r_set;
    logic [TAG_W-1:0]    r_tag;
    logic [1:0]          r_act;

    logic [31:0]         r_hits, r_misses, r_evicts;
    logic [31:0]         n_hits, n_misses, n_evicts;
    logic                r_out_valid;
    t_rsp                r_out;

    logic [SETB_W-1:0]   setb_eff;
    logic [WAYS_W-1:0]   ways_eff;
    logic [ADDR_W-1:0]   addr_sh;
    logic [SET_W:0]      one_sh;
    logic [SET_W-1:0]    set_mask;
    logic [SET_W-1:0]    in_set;
    logic [SHIFT_W-1:0]  tag_sh;
    logic [TAG_W-1:0]    in_tag;

    logic                accept;
    logic                out_free;
    logic                step;
    t_set_row            row_src;
    t_set_row            acc_row;
    t_outcome            acc_outcome;

    // address split
    always_comb begin
        setb_eff = (r_set_bits > SETB_W'(MAX_SET_BITS)) ? SETB_W'(MAX_SET_BITS) : r_set_bits;
        addr_sh  = i_req.address >> r_blk_bits;
        one_sh   = (SET_W + 1)'(1) << setb_eff;
        set_mask = SET_W'(one_sh - (SET_W + 1)'(1));
        in_set   = addr_sh[SET_W-1:0] & set_mask;
        tag_sh   = SHIFT_W'(setb_eff) + SHIFT_W'(r_blk_bits);
        in_tag   = (tag_sh >= SHIFT_W'(ADDR_W)) ? '0 : (i_req.address >> tag_sh);
    end

    always_comb begin
        priority if (r_ways == '0) begin
            ways_eff = WAYS_W'(1);
        end else if (r_ways > WAYS_W'(MAX_WAYS)) begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end else begin
            ways_eff = r_ways;
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign step     = ((r_state == S_EVAL) || (r_state == S_MOD2)) && out_free;

    // never-written sets read as all invalid, rank zero
    always_comb begin
        if (r_state == S_MOD2) begin
            row_src = r_row_hold;
        end else if (r_rd_live) begin
            row_src = r_rd_row;
        end else begin
            row_src = '0;
        end
    end

    salc_access u_access (
        .i_row     (row_src),
        .i_tag     (r_tag),
        .i_ways    (ways_eff),
        .o_row     (acc_row),
        .o_outcome (acc_outcome)
    );

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        unique case (acc_outcome)
            OUT_HIT: begin
                n_hits = r_hits + 32'd1;
            end
            OUT_MISS: begin
                n_misses = r_misses + 32'd1;
            end
            OUT_EVICT: begin
                n_misses = r_misses + 32'd1;
                n_evicts = r_evicts + 32'd1;
            end
            default: begin
                n_hits = r_hits;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req.action != ACT_IGNORE)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (out_free) begin
                    n_state = (r_act == ACT_MODIFY) ? S_MOD2 : S_IDLE;
                end
            end
            S_MOD2: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // tag memory: one row per set, registered read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_row <= r_mem[in_set];
        end
        if (step) begin
            r_mem[r_set] <= acc_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= in_set;
            r_tag <= in_tag;
            r_act <= i_req.action;
        end
        if (step) begin
            r_row_hold           <= acc_row;
            r_out.outcome        <= acc_outcome;
            r_out.last_of_item   <= (r_state == S_MOD2) || (r_act != ACT_MODIFY);
            r_out.hit_total      <= n_hits;
            r_out.miss_total     <= n_misses;
            r_out.eviction_total <= n_evicts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_set_bits  <= '0;
            r_blk_bits  <= '0;
            r_ways      <= WAYS_W'(1);
            r_set_live  <= '0;
            r_rd_live   <= 1'b0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                if (i_cfg_idx == CFG_SET_BITS) begin
                    r_set_bits <= i_cfg_wdata[SETB_W-1:0];
                end
                if (i_cfg_idx == CFG_BLK_BITS) begin
                    r_blk_bits <= i_cfg_wdata[BLKB_W-1:0];
                end
                if (i_cfg_idx == CFG_WAYS) begin
                    r_ways <= i_cfg_wdata[WAYS_W-1:0];
                end
            end
            if (accept) begin
                r_rd_live <= r_set_live[in_set];
            end
            if (step) begin
                r_set_live[r_set] <= 1'b1;
                r_hits            <= n_hits;
                r_misses          <= n_misses;
                r_evicts          <= n_evicts;
                r_out_valid       <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // second access of a modify finds the line just filled or touched
    a_mod2_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD2 && out_free) |=> (o_rsp.outcome == OUT_HIT && o_rsp.last_of_item))
        else $error("second access of modify did not hit");

    a_accept_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.action != ACT_IGNORE) |=> (r_state == S_EVAL))
        else $error("accepted request did not start an access");

    a_eval_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && out_free) |=>
            (o_valid && (o_rsp.last_of_item == ($past(r_act) != ACT_MODIFY))))
        else $error("access step did not present its result");

    a_totals_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> ((r_hits - $past(r_hits)) + (r_misses - $past(r_misses)) == 32'd1))
        else $error("access did not count exactly one hit or miss");

endmodule

>>> verif/set_assoc_lru_cache_tags_tb.sv
// Self-checking testbench for the set-associative LRU cache tag block.
module set_assoc_lru_cache_tags_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import salc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;
    localparam int PRINT_LIMIT  = 40;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_req                  i_req       = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_rsp                  o_rsp;

    set_assoc_lru_cache_tags dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp)
    );

    // shadow copy of the tag array, ranks, totals and configuration
    bit                line_ok    [NUM_SETS][MAX_WAYS];
    logic [TAG_W-1:0]  line_tag_q [NUM_SETS][MAX_WAYS];
    int                line_age   [NUM_SETS][MAX_WAYS];
    logic [31:0]       hit_cnt   = '0;
    logic [31:0]       miss_cnt  = '0;
    logic [31:0]       evict_cnt = '0;
    logic [SETB_W-1:0] cur_set_bits = '0;
    logic [BLKB_W-1:0] cur_blk_bits = '0;
    logic [WAYS_W-1:0] cur_ways     = WAYS_W'(1);

    t_req pending_requests [$];
    t_rsp expected_outcomes [$];

    int mismatches  = 0;
    int cycle_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    function automatic int eff_set_bits();
        return (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
    endfunction

    function automatic int eff_ways();
        if (cur_ways == 0)
            return 1;
        return (cur_ways > MAX_WAYS) ? MAX_WAYS : int'(cur_ways);
    endfunction

    // touched way becomes most recent; younger valid ways age by one
    function automatic void age_update(int set_i, int ways, int w, int old_rank);
        int j;
        for (j = 0; j < ways; j++) begin
            if (j != w && line_ok[set_i][j] && line_age[set_i][j] < old_rank &&
                line_age[set_i][j] < MAX_WAYS - 1)
                line_age[set_i][j]++;
        end
        line_age[set_i][w] = 0;
    endfunction

    function automatic t_outcome cache_access(logic [ADDR_W-1:0] addr);
        int s, b, ways, set_i, victim, j;
        logic [TAG_W-1:0] tg;
        s     = eff_set_bits();
        b     = int'(cur_blk_bits);
        ways  = eff_ways();
        set_i = int'((addr >> b) & ((32'd1 << s) - 32'd1));
        tg    = (s + b >= ADDR_W) ? '0 : TAG_W'(addr >> (s + b));
        for (j = 0; j < ways; j++) begin
            if (line_ok[set_i][j] && line_tag_q[set_i][j] == tg) begin
                age_update(set_i, ways, j, line_age[set_i][j]);
                hit_cnt++;
                return OUT_HIT;
            end
        end
        miss_cnt++;
        for (j = 0; j < ways; j++) begin
            if (!line_ok[set_i][j]) begin
                line_ok[set_i][j]    = 1'b1;
                line_tag_q[set_i][j] = tg;
                age_update(set_i, ways, j, 255);
                return OUT_MISS;
            end
        end
        victim = 0;
        for (j = 1; j < ways; j++) begin
            if (line_age[set_i][j] > line_age[set_i][victim])
                victim = j;
        end
        line_tag_q[set_i][victim] = tg;
        age_update(set_i, ways, victim, 255);
        evict_cnt++;
        return OUT_EVICT;
    endfunction

    // mostly addresses from a small pool of sets and tags so hits and evictions occur
    function automatic logic [ADDR_W-1:0] make_address();
        int s, b;
        logic [ADDR_W-1:0] a;
        s = eff_set_bits();
        b = int'(cur_blk_bits);
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        a = $urandom() & ((32'd1 << b) - 32'd1);
        a = a | (((ADDR_W'($urandom_range(0, 3))) & ((32'd1 << s) - 32'd1)) << b);
        if (s + b < ADDR_W)
            a = a | (ADDR_W'($urandom_range(0, eff_ways() + 2)) << (s + b));
        return a;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic add_request(logic [1:0] act, logic [ADDR_W-1:0] addr);
        t_req r;
        r.action  = act;
        r.address = addr;
        pending_requests.push_back(r);
    endtask

    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_idle();
        while (pending_requests.size() != 0 || i_valid || expected_outcomes.size() != 0)
            @(negedge i_clk);
        // an ignored request may still be in flight
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CFG_DATA_W'(value);
    endtask

    task automatic configure(int s, int b, int w);
        wait_idle();
        write_reg(CFG_SET_BITS, s);
        write_reg(CFG_BLK_BITS, b);
        write_reg(CFG_WAYS, w);
        cur_set_bits = SETB_W'(s);
        cur_blk_bits = BLKB_W'(b);
        cur_ways     = WAYS_W'(w);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_requests(int target);
        int issued, pick;
        issued = 0;
        while (issued < target) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                add_request(ACT_IGNORE, $urandom());
            end else begin
                case (pick % 3)
                    0: add_request(ACT_LOAD, make_address());
                    1: add_request(ACT_STORE, make_address());
                    default: add_request(ACT_MODIFY, make_address());
                endcase
                issued++;
            end
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // request driver; expectations are computed at acceptance
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall && i_req.action != ACT_IGNORE) begin
                exp_rsp.outcome        = cache_access(i_req.address);
                exp_rsp.last_of_item   = (i_req.action != ACT_MODIFY);
                exp_rsp.hit_total      = hit_cnt;
                exp_rsp.miss_total     = miss_cnt;
                exp_rsp.eviction_total = evict_cnt;
                expected_outcomes.push_back(exp_rsp);
                if (i_req.action == ACT_MODIFY) begin
                    exp_rsp.outcome        = cache_access(i_req.address);
                    exp_rsp.last_of_item   = 1'b1;
                    exp_rsp.hit_total      = hit_cnt;
                    exp_rsp.miss_total     = miss_cnt;
                    exp_rsp.eviction_total = evict_cnt;
                    expected_outcomes.push_back(exp_rsp);
                end
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 2);
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    i_req   <= pending_requests.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected, outcome %0d",
                                              o_rsp.outcome));
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_rsp.outcome !== want.outcome)
                        report_mismatch($sformatf("outcome got %0d want %0d",
                                                  o_rsp.outcome, want.outcome));
                    if (o_rsp.last_of_item !== want.last_of_item)
                        report_mismatch($sformatf("last_of_item got %0b want %0b",
                                                  o_rsp.last_of_item, want.last_of_item));
                    if (o_rsp.hit_total !== want.hit_total)
                        report_mismatch($sformatf("hit_total got %0d want %0d",
                                                  o_rsp.hit_total, want.hit_total));
                    if (o_rsp.miss_total !== want.miss_total)
                        report_mismatch($sformatf("miss_total got %0d want %0d",
                                                  o_rsp.miss_total, want.miss_total));
                    if (o_rsp.eviction_total !== want.eviction_total)
                        report_mismatch($sformatf("eviction_total got %0d want %0d",
                                                  o_rsp.eviction_total, want.eviction_total));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: one way, whole address is the tag
        add_request(ACT_LOAD, 32'h0000_0000);
        add_request(ACT_LOAD, 32'h0000_0000);
        add_request(ACT_STORE, 32'hFFFF_FFFF);
        add_request(ACT_MODIFY, 32'h0000_0000);
        add_request(ACT_IGNORE, 32'hFFFF_FFFF);
        add_request(ACT_LOAD, 32'h0000_0000);

        // two ways, LRU order in set 1
        configure(2, 4, 2);
        add_request(ACT_LOAD, 32'h0000_0050);
        add_request(ACT_STORE, 32'h0000_0090);
        add_request(ACT_LOAD, 32'h0000_0050);
        add_request(ACT_LOAD, 32'h0000_00D0);
        add_request(ACT_MODIFY, 32'h0000_0090);
        add_request(ACT_LOAD, 32'h0000_00D0);
        add_request(ACT_STORE, 32'h0000_0050);

        // set bits clamped, tag shift reaches the address width: tag is zero
        configure(12, 24, 3);
        add_request(ACT_LOAD, 32'hFFFF_FFFF);
        add_request(ACT_LOAD, 32'hFF00_0000);
        add_request(ACT_MODIFY, 32'h0123_4567);

        // zero ways acts as one, no set bits, tag is the top address bit
        configure(0, 31, 0);
        add_request(ACT_LOAD, 32'h0000_0000);
        add_request(ACT_LOAD, 32'h7FFF_FFFF);
        add_request(ACT_LOAD, 32'h8000_0000);

        configure(8, 0, 8);
        random_requests(70);
        // fewer ways, then back: inactive ways keep their lines
        configure(8, 0, 2);
        random_requests(50);
        configure(8, 0, 8);
        random_requests(50);
        configure(15, 31, 15);
        random_requests(40);
        configure(8, 24, 8);
        random_requests(60);
        configure(9, 3, 9);
        random_requests(60);
        configure(0, 0, 1);
        random_requests(40);
        repeat (3) begin
            configure($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 15));
            random_requests(50);
        end
        wait_idle();
        calm = 1'b1;
        configure(3, 5, 4);
        random_requests(50);

        wait_idle();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
